// ===== rtl/mmae_pkg.sv =====
// Shared package for the memory-to-memory ALU executor.
// Holds the transfer payload types, opcode and status codes, and the microcode ROM.
// Used by the executor top level and the checker; depends on nothing else.
package mmae_pkg;

  localparam int unsigned MEM_DEPTH_DEF   = 256;
  localparam int unsigned WORD_BITS_DEF   = 32;
  localparam int unsigned ADDR_FIELD_BITS = 8;
  localparam int unsigned PC_BITS         = 5;

  localparam logic [3:0] OPC_ADD   = 4'd0;
  localparam logic [3:0] OPC_SUB   = 4'd1;
  localparam logic [3:0] OPC_MUL   = 4'd2;
  localparam logic [3:0] OPC_DIV   = 4'd3;
  localparam logic [3:0] OPC_MOD   = 4'd4;
  localparam logic [3:0] OPC_READ  = 4'd5;
  localparam logic [3:0] OPC_WRITE = 4'd6;
  localparam logic [3:0] OPC_STORE = 4'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADOP   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  typedef struct packed {
    logic [3:0]                 mode;
    logic [ADDR_FIELD_BITS-1:0] dest_addr;
    logic [ADDR_FIELD_BITS-1:0] src_a;
    logic [ADDR_FIELD_BITS-1:0] src_b;
    logic signed [31:0]         value_in;
  } instr_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [1:0] {RS_A = 2'd0, RS_B = 2'd1, RS_D = 2'd2} rsel_t;
  typedef enum logic [1:0] {MS_LL = 2'd0, MS_LH = 2'd1, MS_HL = 2'd2} mul_sel_t;
  typedef enum logic [1:0] {AC_HOLD = 2'd0, AC_LOAD = 2'd1, AC_ADD = 2'd2} acc_op_t;
  typedef enum logic [2:0] {
    WS_NONE = 3'd0, WS_ADD = 3'd1, WS_SUB = 3'd2, WS_MUL = 3'd3, WS_DIV = 3'd4,
    WS_IMM = 3'd5
  } wsrc_t;
  typedef enum logic [2:0] {
    RES_NONE = 3'd0, RES_OK = 3'd1, RES_WRITE = 3'd2, RES_BADOP = 3'd3, RES_DIVZ = 3'd4
  } res_t;
  typedef enum logic [2:0] {
    J_NEXT = 3'd0, J_DECODE = 3'd1, J_EXEC = 3'd2, J_YZERO = 3'd3, J_DIVBUSY = 3'd4
  } jmp_t;

  typedef struct packed {
    rsel_t              rsel;
    logic               ld_x;
    logic               ld_y;
    logic               mul_en;
    mul_sel_t           mul_sel;
    acc_op_t            acc_op;
    logic               div_start;
    wsrc_t              wsrc;
    res_t               res;
    jmp_t               jmp;
    logic [PC_BITS-1:0] target;
  } uword_t;

  localparam logic [PC_BITS-1:0] P_DECODE = 5'd0;
  localparam logic [PC_BITS-1:0] P_FETCH  = 5'd1;
  localparam logic [PC_BITS-1:0] P_FETCHB = 5'd2;
  localparam logic [PC_BITS-1:0] P_CAPY   = 5'd3;
  localparam logic [PC_BITS-1:0] P_ADD    = 5'd4;
  localparam logic [PC_BITS-1:0] P_SUB    = 5'd5;
  localparam logic [PC_BITS-1:0] P_MUL    = 5'd6;
  localparam logic [PC_BITS-1:0] P_MUL1   = 5'd7;
  localparam logic [PC_BITS-1:0] P_MUL2   = 5'd8;
  localparam logic [PC_BITS-1:0] P_MUL3   = 5'd9;
  localparam logic [PC_BITS-1:0] P_MULW   = 5'd10;
  localparam logic [PC_BITS-1:0] P_DIV    = 5'd11;
  localparam logic [PC_BITS-1:0] P_DIVW   = 5'd12;
  localparam logic [PC_BITS-1:0] P_DIVR   = 5'd13;
  localparam logic [PC_BITS-1:0] P_DZ     = 5'd14;
  localparam logic [PC_BITS-1:0] P_IMM    = 5'd15;
  localparam logic [PC_BITS-1:0] P_WRD    = 5'd16;
  localparam logic [PC_BITS-1:0] P_WRD1   = 5'd17;
  localparam logic [PC_BITS-1:0] P_WRD2   = 5'd18;
  localparam logic [PC_BITS-1:0] P_BAD    = 5'd19;

  function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      P_DECODE: w.jmp = J_DECODE;
      P_FETCH:  w.rsel = RS_A;
      P_FETCHB: begin
        w.rsel = RS_B;
        w.ld_x = 1'b1;
      end
      P_CAPY: begin
        w.ld_y = 1'b1;
        w.jmp  = J_EXEC;
      end
      P_ADD: begin
        w.wsrc = WS_ADD;
        w.res  = RES_OK;
      end
      P_SUB: begin
        w.wsrc = WS_SUB;
        w.res  = RES_OK;
      end
      P_MUL: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MS_LL;
      end
      P_MUL1: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MS_LH;
        w.acc_op  = AC_LOAD;
      end
      P_MUL2: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MS_HL;
        w.acc_op  = AC_ADD;
      end
      P_MUL3:   w.acc_op = AC_ADD;
      P_MULW: begin
        w.wsrc = WS_MUL;
        w.res  = RES_OK;
      end
      P_DIV: begin
        w.div_start = 1'b1;
        w.jmp       = J_YZERO;
        w.target    = P_DZ;
      end
      P_DIVW: begin
        w.jmp    = J_DIVBUSY;
        w.target = P_DIVW;
      end
      P_DIVR: begin
        w.wsrc = WS_DIV;
        w.res  = RES_OK;
      end
      P_DZ:     w.res = RES_DIVZ;
      P_IMM: begin
        w.wsrc = WS_IMM;
        w.res  = RES_OK;
      end
      P_WRD:    w.rsel = RS_D;
      P_WRD1: begin
        w.rsel = RS_D;
        w.ld_x = 1'b1;
      end
      P_WRD2:   w.res = RES_WRITE;
      P_BAD:    w.res = RES_BADOP;
      default:  w.res = RES_BADOP;
    endcase
    return w;
  endfunction

  function automatic logic [PC_BITS-1:0] decode_entry(input logic [3:0] mode);
    logic [PC_BITS-1:0] e;
    if (mode inside {OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD}) begin
      e = P_FETCH;
    end else if (mode inside {OPC_READ, OPC_STORE}) begin
      e = P_IMM;
    end else if (mode == OPC_WRITE) begin
      e = P_WRD;
    end else begin
      e = P_BAD;
    end
    return e;
  endfunction

  function automatic logic [PC_BITS-1:0] exec_entry(input logic [3:0] mode);
    logic [PC_BITS-1:0] e;
    case (mode)
      OPC_ADD: e = P_ADD;
      OPC_SUB: e = P_SUB;
      OPC_MUL: e = P_MUL;
      default: e = P_DIV;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/mmae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
module mmae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mmae_div.sv =====
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Self-contained; instantiated by the executor top level.
module mmae_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem,
  output logic             busy
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    count;
  logic [WIDTH-1:0] d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem, quot[WIDTH-1]};
  assign diff    = shifted - {1'b0, d};
  assign busy    = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(WIDTH);
    end else if (busy) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d    <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem  <= diff[WIDTH-1:0];
        quot <= {quot[WIDTH-2:0], 1'b1};
      end else begin
        rem  <= shifted[WIDTH-1:0];
        quot <= {quot[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/memory_to_memory_alu_executor.sv =====
// One instruction at a time; the next transfer is taken the cycle after a result is registered.
// Reset (synchronous, active high) starts a clearing pass that zeroes every word of the
// data memory; instr_stall stays high until it ends.
// Depends on mmae_pkg, mmae_ram and mmae_div.
module memory_to_memory_alu_executor #(
  parameter int unsigned MEM_DEPTH = mmae_pkg::MEM_DEPTH_DEF,
  parameter int unsigned WORD_BITS = mmae_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  mmae_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output mmae_pkg::result_t result
);

  localparam int unsigned AW    = $clog2(MEM_DEPTH);
  localparam int unsigned ASPAN = 1 << mmae_pkg::ADDR_FIELD_BITS;
  localparam int unsigned H     = (WORD_BITS + 1) / 2;
  localparam int unsigned PW    = 2 * H;
  localparam int unsigned PCW   = mmae_pkg::PC_BITS;

  logic [AW-1:0] amod [ASPAN];

  for (genvar i = 0; i < ASPAN; i++) begin : g_amod
    localparam int unsigned R = i % MEM_DEPTH;
    assign amod[i] = AW'(R);
  end

  mmae_pkg::instr_t  op;
  mmae_pkg::uword_t  uw;
  mmae_pkg::result_t res_next;
  logic [AW-1:0]        da, aa, ba, raddr, waddr, clr_addr;
  logic                 busy, busy_next, clr_active, accept, out_free, fire, ram_we, div_go;
  logic [PCW-1:0]       pc, pc_next;
  logic [WORD_BITS-1:0] x, y, acc, rdata, wval, wdata, mx, my, quot, rem, divres, imm;
  logic [H-1:0]         ma, mb;
  logic [PW-1:0]        prod;
  logic                 div_busy, is_div, neg;

  assign accept      = instr_valid && !instr_stall;
  assign instr_stall = busy || clr_active;
  assign uw          = mmae_pkg::ucode(pc);
  assign out_free    = !result_valid || !result_stall;
  assign fire        = busy && (uw.res != mmae_pkg::RES_NONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= instr;
      da <= amod[instr.dest_addr];
      aa <= amod[instr.src_a];
      ba <= amod[instr.src_b];
    end
  end

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (accept) begin
        busy_next = 1'b1;
        pc_next   = mmae_pkg::P_DECODE;
      end
    end else if (uw.res != mmae_pkg::RES_NONE) begin
      if (out_free) begin
        busy_next = 1'b0;
        pc_next   = mmae_pkg::P_DECODE;
      end
    end else begin
      case (uw.jmp)
        mmae_pkg::J_DECODE:  pc_next = mmae_pkg::decode_entry(op.mode);
        mmae_pkg::J_EXEC:    pc_next = mmae_pkg::exec_entry(op.mode);
        mmae_pkg::J_YZERO:   pc_next = (y == '0) ? uw.target : pc + PCW'(1);
        mmae_pkg::J_DIVBUSY: pc_next = div_busy ? uw.target : pc + PCW'(1);
        default:             pc_next = pc + PCW'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= mmae_pkg::P_DECODE;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  always_comb begin
    case (uw.rsel)
      mmae_pkg::RS_A: raddr = aa;
      mmae_pkg::RS_B: raddr = ba;
      mmae_pkg::RS_D: raddr = da;
      default:        raddr = aa;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.ld_x) begin
      x <= rdata;
    end
    if (uw.ld_y) begin
      y <= rdata;
    end
  end

  always_comb begin
    case (uw.mul_sel)
      mmae_pkg::MS_LL: begin
        ma = x[H-1:0];
        mb = y[H-1:0];
      end
      mmae_pkg::MS_LH: begin
        ma = x[H-1:0];
        mb = H'(y >> H);
      end
      mmae_pkg::MS_HL: begin
        ma = H'(x >> H);
        mb = y[H-1:0];
      end
      default: begin
        ma = x[H-1:0];
        mb = y[H-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.mul_en) begin
      prod <= PW'(ma) * PW'(mb);
    end
    case (uw.acc_op)
      mmae_pkg::AC_LOAD: acc <= WORD_BITS'(prod);
      mmae_pkg::AC_ADD:  acc <= acc + (WORD_BITS'(prod) << H);
      default:           acc <= acc;
    endcase
  end

  assign mx     = x[WORD_BITS-1] ? (WORD_BITS'(0) - x) : x;
  assign my     = y[WORD_BITS-1] ? (WORD_BITS'(0) - y) : y;
  assign div_go = busy && uw.div_start && (y != '0);

  mmae_div #(
    .WIDTH(WORD_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_go),
    .dividend(mx),
    .divisor (my),
    .quot    (quot),
    .rem     (rem),
    .busy    (div_busy)
  );

  assign is_div = (op.mode == mmae_pkg::OPC_DIV);
  assign neg    = is_div ? (x[WORD_BITS-1] ^ y[WORD_BITS-1]) : x[WORD_BITS-1];
  assign divres = neg ? (WORD_BITS'(0) - (is_div ? quot : rem)) : (is_div ? quot : rem);
  assign imm    = WORD_BITS'(op.value_in);

  always_comb begin
    case (uw.wsrc)
      mmae_pkg::WS_ADD: wval = x + y;
      mmae_pkg::WS_SUB: wval = x - y;
      mmae_pkg::WS_MUL: wval = acc;
      mmae_pkg::WS_DIV: wval = divres;
      mmae_pkg::WS_IMM: wval = imm;
      default:          wval = '0;
    endcase
  end

  assign ram_we = clr_active || (fire && (uw.wsrc != mmae_pkg::WS_NONE));
  assign waddr  = clr_active ? clr_addr : da;
  assign wdata  = clr_active ? '0 : wval;

  mmae_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    res_next = '0;
    case (uw.res)
      mmae_pkg::RES_WRITE: begin
        res_next.out_value = 32'($signed(x));
        res_next.out_valid = 1'b1;
        res_next.status    = mmae_pkg::ST_OK;
      end
      mmae_pkg::RES_BADOP: res_next.status = mmae_pkg::ST_BADOP;
      mmae_pkg::RES_DIVZ:  res_next.status = mmae_pkg::ST_DIVZERO;
      default:             res_next.status = mmae_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/mmae_chk.sv =====
// Port-level checker for the executor, attached to the top level by bind.
// Depends on mmae_pkg for the payload types and status codes.
module mmae_chk (
  input logic              clk,
  input logic              rst,
  input logic              instr_valid,
  input logic              instr_stall,
  input mmae_pkg::instr_t  instr,
  input logic              result_valid,
  input logic              result_stall,
  input mmae_pkg::result_t result
);

  a_reset_stall: assert property (@(posedge clk) rst |=> instr_stall)
    else $error("instr_stall low right after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (instr_valid && !instr_stall) |=> instr_stall)
    else $error("second instruction transfer while one is in flight");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_valid) |-> (result.status == mmae_pkg::ST_OK))
    else $error("write result with non-ok status");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.out_valid) |-> (result.out_value == '0))
    else $error("non-write result carries a value");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind memory_to_memory_alu_executor mmae_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .instr_valid (instr_valid),
  .instr_stall (instr_stall),
  .instr       (instr),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
